// ===== rtl/tlh_pkg.sv =====
// Shared codes, field widths and control types of the timer heap queue.
package tlh_pkg;

  localparam int DL_W   = 48;
  localparam int TO_W   = 32;
  localparam int REM_W  = 31;
  localparam int TID_W  = 6;
  localparam int ACT_W  = 2;
  localparam int KIND_W = 3;

  localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CANCEL = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_EXPIRE = 2'd3;

  localparam logic [KIND_W-1:0] KIND_ADD     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CANCEL  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_NEXT    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_EXPIRED = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NONE    = 3'd4;

  localparam logic [REM_W-1:0] REM_MAX = '1;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE,
    S_ADD0, S_ADD1, S_ADD2, S_UP, S_UPC,
    S_CAN0, S_CAN1, S_CAN2,
    S_TOP, S_TOPC, S_POP1, S_DN, S_DNL, S_DNR,
    S_RES
  } state_t;

  typedef struct packed {
    logic h_re;
    logic h_we;
    logic s_re;
    logic s_we;
  } mem_ctl_t;

endpackage

// ===== rtl/tlh_mem.sv =====
// Heap entry memory and per-id slot memory, one write and one registered read port each.
module tlh_mem #(
  parameter int CAPACITY = 64,
  parameter int ID_COUNT = 64,
  localparam int PW = $clog2(CAPACITY),
  localparam int IW = $clog2(ID_COUNT),
  localparam int EW = tlh_pkg::DL_W + IW + 2,
  localparam int SW = PW + 1
) (
  input  logic             clk,
  input  tlh_pkg::mem_ctl_t ctl,
  input  logic [PW-1:0]    h_raddr,
  input  logic [PW-1:0]    h_waddr,
  input  logic [EW-1:0]    h_wdata,
  output logic [EW-1:0]    h_rdata,
  input  logic [IW-1:0]    s_raddr,
  input  logic [IW-1:0]    s_waddr,
  input  logic [SW-1:0]    s_wdata,
  output logic [SW-1:0]    s_rdata
);

  logic [EW-1:0] heap_mem [CAPACITY];
  logic [SW-1:0] slot_mem [ID_COUNT];

  always_ff @(posedge clk) begin
    if (ctl.h_we) begin
      heap_mem[h_waddr] <= h_wdata;
    end
    if (ctl.h_re) begin
      h_rdata <= heap_mem[h_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s_we) begin
      slot_mem[s_waddr] <= s_wdata;
    end
    if (ctl.s_re) begin
      s_rdata <= slot_mem[s_raddr];
    end
  end

endmodule

// ===== rtl/tlh_seq.sv =====
// Sequencer for heap add, cancel, query and expire with hole-based sifting.
module tlh_seq #(
  parameter int CAPACITY = 64,
  parameter int ID_COUNT = 64,
  localparam int PW = $clog2(CAPACITY),
  localparam int IW = $clog2(ID_COUNT),
  localparam int EW = tlh_pkg::DL_W + IW + 2,
  localparam int SW = PW + 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_fire,
  input  logic [tlh_pkg::ACT_W-1:0]   action,
  input  logic [tlh_pkg::TID_W-1:0]   timer_id,
  input  logic [tlh_pkg::TO_W-1:0]    timeout_ms,
  input  logic [tlh_pkg::DL_W-1:0]    now_ms,
  output logic                        idle,
  input  logic                        out_free,
  output logic                        emit,
  output logic [tlh_pkg::KIND_W-1:0]  res_kind,
  output logic [tlh_pkg::TID_W-1:0]   res_id,
  output logic [tlh_pkg::REM_W-1:0]   res_rem,
  output logic                        res_none,
  output logic                        res_err,
  output logic                        res_last,
  output tlh_pkg::mem_ctl_t           ctl,
  output logic [PW-1:0]               h_raddr,
  output logic [PW-1:0]               h_waddr,
  output logic [EW-1:0]               h_wdata,
  input  logic [EW-1:0]               h_rdata,
  output logic [IW-1:0]               s_raddr,
  output logic [IW-1:0]               s_waddr,
  output logic [SW-1:0]               s_wdata,
  input  logic [SW-1:0]               s_rdata
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = PW + 2;

  typedef struct packed {
    logic [tlh_pkg::DL_W-1:0] dl;
    logic [IW-1:0]            owner;
    logic                     dead;
    logic                     cur;
  } ent_t;

  typedef struct packed {
    logic          valid;
    logic [PW-1:0] pos;
  } slot_t;

  tlh_pkg::state_t state, state_next;

  logic [CW-1:0]            cnt;
  logic [tlh_pkg::ACT_W-1:0] act;
  logic [tlh_pkg::DL_W-1:0] now;
  ent_t                     ent;
  ent_t                     lch;
  logic [PW-1:0]            pos;
  logic [IW-1:0]            clr;
  logic                     have_res;

  ent_t  rd;
  slot_t srd;
  ent_t  cand;
  logic [PW-1:0] cand_pos;
  logic [PW-1:0] parent;
  logic [PW-1:0] lastpos;
  logic [LW-1:0] left_w, right_w;
  logic has_l, has_r, up_go, dn_go, due, pop_go, emit_mid;
  logic id_bad, full;
  logic [tlh_pkg::DL_W:0]   sum;
  logic [tlh_pkg::DL_W-1:0] dl_sat;
  logic [tlh_pkg::DL_W-1:0] diff;
  logic [tlh_pkg::REM_W-1:0] rem;

  assign rd  = ent_t'(h_rdata);
  assign srd = slot_t'(s_rdata);

  always_comb begin
    sum     = {1'b0, now_ms} + (tlh_pkg::DL_W + 1)'(timeout_ms);
    dl_sat  = sum[tlh_pkg::DL_W] ? '1 : sum[tlh_pkg::DL_W-1:0];
    id_bad  = 32'(timer_id) >= 32'(ID_COUNT);
    full    = cnt == CW'(CAPACITY);
    parent  = (pos - PW'(1)) >> 1;
    lastpos = PW'(cnt - CW'(1));
    left_w  = (LW'(pos) << 1) + LW'(1);
    right_w = left_w + LW'(1);
    has_l   = left_w < LW'(cnt);
    has_r   = right_w < LW'(cnt);
    if (state == tlh_pkg::S_DNR && rd.dl < lch.dl) begin
      cand     = rd;
      cand_pos = PW'(right_w);
    end else if (state == tlh_pkg::S_DNR) begin
      cand     = lch;
      cand_pos = PW'(left_w);
    end else begin
      cand     = rd;
      cand_pos = PW'(left_w);
    end
    dn_go = cand.dl < ent.dl;
    up_go = ent.dl < rd.dl;
    due   = rd.dl <= now;
    diff  = rd.dl - now;
    if (rd.dl <= now) begin
      rem = '0;
    end else if (diff > tlh_pkg::DL_W'(tlh_pkg::REM_MAX)) begin
      rem = tlh_pkg::REM_MAX;
    end else begin
      rem = diff[tlh_pkg::REM_W-1:0];
    end
    pop_go = state == tlh_pkg::S_TOPC &&
             (rd.dead || (act == tlh_pkg::ACT_EXPIRE && due && (!have_res || out_free)));
    emit_mid = state == tlh_pkg::S_TOPC && !rd.dead && act == tlh_pkg::ACT_EXPIRE &&
               due && have_res && out_free;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      tlh_pkg::S_CLR: if (clr == IW'(ID_COUNT - 1)) state_next = tlh_pkg::S_IDLE;
      tlh_pkg::S_IDLE: begin
        if (in_fire) begin
          unique case (action)
            tlh_pkg::ACT_ADD:
              state_next = (id_bad || full) ? tlh_pkg::S_RES : tlh_pkg::S_ADD0;
            tlh_pkg::ACT_CANCEL:
              state_next = id_bad ? tlh_pkg::S_RES : tlh_pkg::S_CAN0;
            default: state_next = tlh_pkg::S_TOP;
          endcase
        end
      end
      tlh_pkg::S_ADD0: state_next = tlh_pkg::S_ADD1;
      tlh_pkg::S_ADD1: state_next = srd.valid ? tlh_pkg::S_ADD2 : tlh_pkg::S_UP;
      tlh_pkg::S_ADD2: state_next = tlh_pkg::S_UP;
      tlh_pkg::S_UP:   state_next = (pos == '0) ? tlh_pkg::S_RES : tlh_pkg::S_UPC;
      tlh_pkg::S_UPC:  state_next = up_go ? tlh_pkg::S_UP : tlh_pkg::S_RES;
      tlh_pkg::S_CAN0: state_next = tlh_pkg::S_CAN1;
      tlh_pkg::S_CAN1: state_next = srd.valid ? tlh_pkg::S_CAN2 : tlh_pkg::S_RES;
      tlh_pkg::S_CAN2: state_next = tlh_pkg::S_RES;
      tlh_pkg::S_TOP:  state_next = (cnt == '0) ? tlh_pkg::S_RES : tlh_pkg::S_TOPC;
      tlh_pkg::S_TOPC: begin
        if (pop_go) begin
          state_next = (cnt == CW'(1)) ? tlh_pkg::S_TOP : tlh_pkg::S_POP1;
        end else if (rd.dead || (act == tlh_pkg::ACT_EXPIRE && due)) begin
          state_next = tlh_pkg::S_TOPC;
        end else begin
          state_next = tlh_pkg::S_RES;
        end
      end
      tlh_pkg::S_POP1: state_next = tlh_pkg::S_DN;
      tlh_pkg::S_DN:   state_next = has_l ? tlh_pkg::S_DNL : tlh_pkg::S_TOP;
      tlh_pkg::S_DNL: begin
        if (has_r) state_next = tlh_pkg::S_DNR;
        else state_next = dn_go ? tlh_pkg::S_DN : tlh_pkg::S_TOP;
      end
      tlh_pkg::S_DNR: state_next = dn_go ? tlh_pkg::S_DN : tlh_pkg::S_TOP;
      tlh_pkg::S_RES: if (out_free) state_next = tlh_pkg::S_IDLE;
      default: state_next = tlh_pkg::S_IDLE;
    endcase
  end

  // Memory requests and result hand-off.
  always_comb begin
    ctl      = '0;
    h_raddr  = '0;
    h_waddr  = pos;
    h_wdata  = ent;
    s_raddr  = ent.owner;
    s_waddr  = ent.owner;
    s_wdata  = {1'b1, pos};
    emit     = 1'b0;
    res_last = 1'b0;
    unique case (state)
      tlh_pkg::S_CLR: begin
        ctl.s_we = 1'b1;
        s_waddr  = clr;
        s_wdata  = '0;
      end
      tlh_pkg::S_ADD0, tlh_pkg::S_CAN0: ctl.s_re = 1'b1;
      tlh_pkg::S_ADD1, tlh_pkg::S_CAN1: begin
        ctl.h_re = srd.valid;
        h_raddr  = srd.pos;
      end
      tlh_pkg::S_ADD2: begin
        ctl.h_we = 1'b1;
        h_waddr  = srd.pos;
        h_wdata  = {rd.dl, rd.owner, rd.dead, 1'b0};
      end
      tlh_pkg::S_CAN2: begin
        ctl.h_we = 1'b1;
        h_waddr  = srd.pos;
        h_wdata  = {rd.dl, rd.owner, 1'b1, rd.cur};
      end
      tlh_pkg::S_UP: begin
        if (pos == '0) begin
          ctl.h_we = 1'b1;
          ctl.s_we = ent.cur;
        end else begin
          ctl.h_re = 1'b1;
          h_raddr  = parent;
        end
      end
      tlh_pkg::S_UPC: begin
        ctl.h_we = 1'b1;
        if (up_go) begin
          h_wdata  = rd;
          s_waddr  = rd.owner;
          ctl.s_we = rd.cur;
        end else begin
          ctl.s_we = ent.cur;
        end
      end
      tlh_pkg::S_TOP: ctl.h_re = cnt != '0;
      tlh_pkg::S_TOPC: begin
        if (pop_go) begin
          ctl.s_we = rd.cur;
          s_waddr  = rd.owner;
          s_wdata  = '0;
          ctl.h_re = cnt != CW'(1);
          h_raddr  = lastpos;
        end
        emit = emit_mid;
      end
      tlh_pkg::S_DN: begin
        if (has_l) begin
          ctl.h_re = 1'b1;
          h_raddr  = PW'(left_w);
        end else begin
          ctl.h_we = 1'b1;
          ctl.s_we = ent.cur;
        end
      end
      tlh_pkg::S_DNL, tlh_pkg::S_DNR: begin
        if (state == tlh_pkg::S_DNL && has_r) begin
          ctl.h_re = 1'b1;
          h_raddr  = PW'(right_w);
        end else begin
          ctl.h_we = 1'b1;
          if (dn_go) begin
            h_wdata  = cand;
            s_waddr  = cand.owner;
            ctl.s_we = cand.cur;
          end else begin
            ctl.s_we = ent.cur;
          end
        end
      end
      tlh_pkg::S_RES: begin
        emit     = out_free;
        res_last = 1'b1;
      end
      default: ;
    endcase
  end

  assign idle = state == tlh_pkg::S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tlh_pkg::S_CLR;
      cnt      <= '0;
      clr      <= '0;
      have_res <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        tlh_pkg::S_CLR: clr <= clr + IW'(1);
        tlh_pkg::S_IDLE: begin
          if (in_fire) begin
            act      <= action;
            now      <= now_ms;
            ent      <= {dl_sat, IW'(timer_id), 1'b0, 1'b1};
            have_res <= 1'b0;
            res_id   <= '0;
            res_rem  <= '0;
            res_none <= 1'b0;
            unique case (action)
              tlh_pkg::ACT_ADD: begin
                res_kind <= tlh_pkg::KIND_ADD;
                res_err  <= id_bad || full;
              end
              tlh_pkg::ACT_CANCEL: begin
                res_kind <= tlh_pkg::KIND_CANCEL;
                res_err  <= id_bad;
              end
              tlh_pkg::ACT_QUERY: begin
                res_kind <= tlh_pkg::KIND_NEXT;
                res_err  <= 1'b0;
              end
              default: begin
                res_kind <= tlh_pkg::KIND_NONE;
                res_err  <= 1'b0;
              end
            endcase
          end
        end
        tlh_pkg::S_ADD0: begin
          pos <= PW'(cnt);
          cnt <= cnt + CW'(1);
        end
        tlh_pkg::S_UPC: if (up_go) pos <= parent;
        tlh_pkg::S_CAN1: if (!srd.valid) res_err <= 1'b1;
        tlh_pkg::S_TOP: if (cnt == '0 && act == tlh_pkg::ACT_QUERY) res_none <= 1'b1;
        tlh_pkg::S_TOPC: begin
          if (!rd.dead && act == tlh_pkg::ACT_QUERY) res_rem <= rem;
          if (pop_go) cnt <= cnt - CW'(1);
          if (pop_go && !rd.dead) begin
            have_res <= 1'b1;
            res_kind <= tlh_pkg::KIND_EXPIRED;
            res_id   <= tlh_pkg::TID_W'(rd.owner);
          end
        end
        tlh_pkg::S_POP1: begin
          ent <= rd;
          pos <= '0;
        end
        tlh_pkg::S_DNL: begin
          lch <= rd;
          if (!has_r && dn_go) pos <= cand_pos;
        end
        tlh_pkg::S_DNR: if (dn_go) pos <= cand_pos;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= CW'(CAPACITY))
    else $error("heap count beyond capacity");
  a_heap_rw: assert property (@(posedge clk) disable iff (rst)
    !(ctl.h_re && ctl.h_we && h_raddr == h_waddr))
    else $error("heap read and write to one entry in one cycle");
  a_slot_rw: assert property (@(posedge clk) disable iff (rst) !(ctl.s_re && ctl.s_we))
    else $error("slot read and write in one cycle");
  a_busy: assert property (@(posedge clk) disable iff (rst) in_fire |=> !idle)
    else $error("accepted word left the sequencer idle");
  a_emit: assert property (@(posedge clk) disable iff (rst) emit |-> out_free)
    else $error("result issued into a full output register");
`endif

endmodule

// ===== rtl/timer_heap_lazy_cancel.sv =====
// Top level of the deadline timer queue: sequencer, memories and output register.
//
//   channel  words                                          flow control
//   in       action, timer_id, timeout_ms, now_ms          in_valid / in_stall
//   out      kind, expired_id, remaining_ms, no_timer,     out_valid / out_stall
//            error, last
//
// One input word is worked on at a time; the cost is set by the single read
// port of the heap memory, which is walked one tree level at a time on the way
// up and on the way down.
// An add reads the id's slot, clears the current flag of an older entry of the
// same id and sifts up; a cancel marks the entry dead; query and expire inspect
// the top, dropping dead entries, and expire pops each due entry and sifts down.
// After reset the slot memory is cleared, one id a cycle, before the first word
// is taken. The output register lets the next input word be accepted while a
// result still waits under out_stall.
module timer_heap_lazy_cancel #(
  parameter int CAPACITY = 64,
  parameter int ID_COUNT = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tlh_pkg::ACT_W-1:0]   action,
  input  logic [tlh_pkg::TID_W-1:0]   timer_id,
  input  logic [tlh_pkg::TO_W-1:0]    timeout_ms,
  input  logic [tlh_pkg::DL_W-1:0]    now_ms,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tlh_pkg::KIND_W-1:0]  kind,
  output logic [tlh_pkg::TID_W-1:0]   expired_id,
  output logic [tlh_pkg::REM_W-1:0]   remaining_ms,
  output logic                        no_timer,
  output logic                        error,
  output logic                        last
);

  localparam int PW = $clog2(CAPACITY);
  localparam int IW = $clog2(ID_COUNT);
  localparam int EW = tlh_pkg::DL_W + IW + 2;
  localparam int SW = PW + 1;

  logic in_fire, idle, out_free, emit;
  logic [tlh_pkg::KIND_W-1:0] res_kind;
  logic [tlh_pkg::TID_W-1:0]  res_id;
  logic [tlh_pkg::REM_W-1:0]  res_rem;
  logic res_none, res_err, res_last;
  tlh_pkg::mem_ctl_t ctl;
  logic [PW-1:0] h_raddr, h_waddr;
  logic [EW-1:0] h_wdata, h_rdata;
  logic [IW-1:0] s_raddr, s_waddr;
  logic [SW-1:0] s_wdata, s_rdata;

  // Words are taken only while the sequencer waits for work.
  assign in_stall = !idle;
  assign in_fire  = in_valid && !in_stall;

  // The output register frees up in the same cycle its word is taken.
  assign out_free = !out_valid || !out_stall;

  tlh_seq #(.CAPACITY(CAPACITY), .ID_COUNT(ID_COUNT)) u_seq (
    .clk, .rst, .in_fire, .action, .timer_id, .timeout_ms, .now_ms,
    .idle, .out_free, .emit, .res_kind, .res_id, .res_rem, .res_none, .res_err,
    .res_last, .ctl, .h_raddr, .h_waddr, .h_wdata, .h_rdata,
    .s_raddr, .s_waddr, .s_wdata, .s_rdata
  );

  tlh_mem #(.CAPACITY(CAPACITY), .ID_COUNT(ID_COUNT)) u_mem (
    .clk, .ctl, .h_raddr, .h_waddr, .h_wdata, .h_rdata,
    .s_raddr, .s_waddr, .s_wdata, .s_rdata
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Payload holds while stalled because emit waits for out_free.
  always_ff @(posedge clk) begin
    if (emit) begin
      kind         <= res_kind;
      expired_id   <= res_id;
      remaining_ms <= res_rem;
      no_timer     <= res_none;
      error        <= res_err;
      last         <= res_last;
    end
  end

endmodule
